### rtl/fccw_pkg.sv
package fccw_pkg;

  localparam int unsigned TABLE_BYTES_DEF = 8192;
  localparam int unsigned MAX_CHAIN_DEF   = 64;

  localparam int unsigned CLUSTER_W   = 12;
  localparam int unsigned BYTE_ADDR_W = 13;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned SECTOR_W    = 17;
  localparam int unsigned STEPS_W     = 7;

  localparam logic [OFFSET_W-1:0]  OFFSET_RESET = 16'd31;
  localparam logic [CLUSTER_W-1:0] END_OF_CHAIN = 12'hFFF;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_WALK = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD0  = 4'b0010,
    S_RD1  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic walk_begin;
    logic rd_hi;
    logic capture_lo;
    logic emit;
    logic last;
    logic trunc;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic end_of_chain;
    logic at_limit;
  } status_t;

endpackage

### rtl/fat12_cluster_chain_walker.sv
// FAT12 cluster chain walker. A transaction with operation 0 writes one byte of the FAT
// table while busy_o stays low. A transaction with operation 1 walks the chain from
// start_cluster_i: each cluster passes through two byte reads (RD0, RD1) through the
// table RAM's single registered read port, then an emit state that unpacks the 12-bit
// entry; busy_o stays high for the whole walk, and each result strobes result_valid_o
// for one cycle, in the cycle after its cluster is evaluated. Results cannot be held
// off. Chains stop at entry 0xFFF or after MaxChain clusters (chain_truncated_o).
// Table bytes read before being loaded return undefined data; there is no clearing pass.
module fat12_cluster_chain_walker #(
  parameter int unsigned TableBytes = fccw_pkg::TABLE_BYTES_DEF,
  parameter int unsigned MaxChain   = fccw_pkg::MAX_CHAIN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             operation_i,
  input  logic [fccw_pkg::BYTE_ADDR_W-1:0] byte_address_i,
  input  logic [fccw_pkg::BYTE_W-1:0]      byte_value_i,
  input  logic [fccw_pkg::CLUSTER_W-1:0]   start_cluster_i,
  input  logic                             cfg_we_i,
  input  logic [fccw_pkg::OFFSET_W-1:0]    cfg_wdata_i,
  output logic                             result_valid_o,
  output logic [fccw_pkg::SECTOR_W-1:0]    sector_address_o,
  output logic [fccw_pkg::CLUSTER_W-1:0]   cluster_number_o,
  output logic                             last_of_chain_o,
  output logic                             chain_truncated_o
);
  import fccw_pkg::*;

  cmd_t    cmd;
  status_t status;

  fccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .operation_i(operation_i),
    .busy_o     (busy_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fccw_datapath #(
    .TableBytes(TableBytes),
    .MaxChain  (MaxChain)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .byte_address_i   (byte_address_i),
    .byte_value_i     (byte_value_i),
    .start_cluster_i  (start_cluster_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_o   (result_valid_o),
    .sector_address_o (sector_address_o),
    .cluster_number_o (cluster_number_o),
    .last_of_chain_o  (last_of_chain_o),
    .chain_truncated_o(chain_truncated_o)
  );

endmodule

### rtl/fccw_ram.sv
module fccw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fccw_datapath.sv
module fccw_datapath #(
  parameter int unsigned TableBytes = 8192,
  parameter int unsigned MaxChain   = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fccw_pkg::cmd_t               cmd_i,
  output fccw_pkg::status_t            status_o,
  input  logic [fccw_pkg::BYTE_ADDR_W-1:0] byte_address_i,
  input  logic [fccw_pkg::BYTE_W-1:0]      byte_value_i,
  input  logic [fccw_pkg::CLUSTER_W-1:0]   start_cluster_i,
  input  logic                             cfg_we_i,
  input  logic [fccw_pkg::OFFSET_W-1:0]    cfg_wdata_i,
  output logic                             result_valid_o,
  output logic [fccw_pkg::SECTOR_W-1:0]    sector_address_o,
  output logic [fccw_pkg::CLUSTER_W-1:0]   cluster_number_o,
  output logic                             last_of_chain_o,
  output logic                             chain_truncated_o
);
  import fccw_pkg::*;

  localparam int unsigned AddrW = $clog2(TableBytes);

  logic [CLUSTER_W-1:0] cluster_q, cluster_d;
  logic [STEPS_W-1:0]   steps_q, steps_d;
  logic [BYTE_W-1:0]    lo_q;
  logic [OFFSET_W-1:0]  offset_q;
  logic                 res_valid_q;
  logic [SECTOR_W-1:0]  res_sector_q;
  logic [CLUSTER_W-1:0] res_cluster_q;
  logic                 res_last_q;
  logic                 res_trunc_q;
  logic                 rd_oor_q;

  logic [BYTE_ADDR_W-1:0] half;
  logic [BYTE_ADDR_W-1:0] base;
  logic [BYTE_ADDR_W-1:0] addr_lo;
  logic [BYTE_ADDR_W-1:0] addr_hi;
  logic [BYTE_ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0]      ram_rdata;
  logic [BYTE_W-1:0]      rdata;
  logic [CLUSTER_W-1:0]   entry;
  logic                   wr_en;

  // entry of cluster c starts at byte 3 * (c / 2), shifted by one for odd c
  assign half    = BYTE_ADDR_W'(cluster_q[CLUSTER_W-1:1]);
  assign base    = half + (half << 1);
  assign addr_lo = base + BYTE_ADDR_W'(cluster_q[0]);
  assign addr_hi = addr_lo + BYTE_ADDR_W'(1);
  assign raddr   = cmd_i.rd_hi ? addr_hi : addr_lo;

  assign wr_en = cmd_i.load && ({1'b0, byte_address_i} < (BYTE_ADDR_W + 1)'(TableBytes));

  fccw_ram #(
    .Width(BYTE_W),
    .Depth(TableBytes)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(byte_address_i[AddrW-1:0]),
    .wdata_i(byte_value_i),
    .raddr_i(raddr[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  // bytes beyond the end of the table read as zero
  assign rdata = rd_oor_q ? '0 : ram_rdata;

  // odd clusters take the high nibble of the middle byte
  assign entry = cluster_q[0] ? {rdata, lo_q[7:4]} : {rdata[3:0], lo_q};

  assign status_o.end_of_chain = (entry == END_OF_CHAIN);
  assign status_o.at_limit     = (steps_q == STEPS_W'(MaxChain - 1));

  always_comb begin
    cluster_d = cluster_q;
    steps_d   = steps_q;
    if (cmd_i.walk_begin) begin
      cluster_d = start_cluster_i;
      steps_d   = '0;
    end else if (cmd_i.advance) begin
      cluster_d = entry;
      steps_d   = steps_q + STEPS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q     <= '0;
      offset_q    <= OFFSET_RESET;
      res_valid_q <= 1'b0;
    end else begin
      steps_q     <= steps_d;
      res_valid_q <= cmd_i.emit;
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cluster_q <= cluster_d;
    rd_oor_q  <= ({1'b0, raddr} >= (BYTE_ADDR_W + 1)'(TableBytes));
    if (cmd_i.capture_lo) begin
      lo_q <= rdata;
    end
    if (cmd_i.emit) begin
      res_sector_q  <= SECTOR_W'(cluster_q) + SECTOR_W'(offset_q);
      res_cluster_q <= cluster_q;
      res_last_q    <= cmd_i.last;
      res_trunc_q   <= cmd_i.trunc;
    end
  end

  assign result_valid_o    = res_valid_q;
  assign sector_address_o  = res_sector_q;
  assign cluster_number_o  = res_cluster_q;
  assign last_of_chain_o   = res_last_q;
  assign chain_truncated_o = res_trunc_q;

  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(cmd_i.emit))
    else $error("result strobe without an emit command");

  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_trunc_q) |-> res_last_q)
    else $error("truncated result not marked as last");

  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> !status_o.at_limit)
    else $error("walk advanced past the chain limit");

endmodule

### rtl/fccw_ctrl.sv
module fccw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              operation_i,
  output logic              busy_o,
  input  fccw_pkg::status_t status_i,
  output fccw_pkg::cmd_t    cmd_o
);
  import fccw_pkg::*;

  state_e state_q, state_d;
  logic   last;

  assign last = status_i.end_of_chain || status_i.at_limit;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (operation_i == OP_WALK) begin
            cmd_o.walk_begin = 1'b1;
            state_d          = S_RD0;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_RD0: begin
        state_d = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd_hi      = 1'b1;
        cmd_o.capture_lo = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit    = 1'b1;
        cmd_o.last    = last;
        cmd_o.trunc   = status_i.at_limit && !status_i.end_of_chain;
        cmd_o.advance = !last;
        state_d       = last ? S_IDLE : S_RD0;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_emit_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> $past(state_q == S_RD1))
    else $error("emit without both table reads");

  a_read_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0) |-> $past(state_q == S_IDLE || state_q == S_EMIT))
    else $error("unexpected entry into first read");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("walk continued after its last result");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import fccw_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [SECTOR_W-1:0]  sector;
    logic [CLUSTER_W-1:0] cluster;
    logic                 last;
    logic                 trunc;
  } sector_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic                   operation_i = OP_LOAD;
  logic [BYTE_ADDR_W-1:0] byte_address_i = '0;
  logic [BYTE_W-1:0]      byte_value_i = '0;
  logic [CLUSTER_W-1:0]   start_cluster_i = '0;
  logic                   cfg_we_i = 1'b0;
  logic [OFFSET_W-1:0]    cfg_wdata_i = '0;
  logic                   result_valid_o;
  logic [SECTOR_W-1:0]    sector_address_o;
  logic [CLUSTER_W-1:0]   cluster_number_o;
  logic                   last_of_chain_o;
  logic                   chain_truncated_o;

  // shadow of the fat and the offset register
  logic [BYTE_W-1:0]   fat_image [TABLE_BYTES_DEF];
  bit                  fat_loaded [TABLE_BYTES_DEF];
  logic [OFFSET_W-1:0] data_offset = OFFSET_RESET;

  sector_result_t       expected_sectors[$];
  sector_result_t       want;
  logic [CLUSTER_W-1:0] known_clusters[$];
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  int                   items_sent = 0;
  int                   pending_gap = 0;
  bit                   no_gaps = 1'b0;

  fat12_cluster_chain_walker i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .operation_i       (operation_i),
    .byte_address_i    (byte_address_i),
    .byte_value_i      (byte_value_i),
    .start_cluster_i   (start_cluster_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .result_valid_o    (result_valid_o),
    .sector_address_o  (sector_address_o),
    .cluster_number_o  (cluster_number_o),
    .last_of_chain_o   (last_of_chain_o),
    .chain_truncated_o (chain_truncated_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // follows the chain through the shadow fat; returns 0 if it would touch an unloaded byte
  function automatic bit trace_chain(input logic [CLUSTER_W-1:0] first, input bit record);
    logic [CLUSTER_W-1:0] cl;
    logic [CLUSTER_W-1:0] nxt;
    int                   lo_idx;
    sector_result_t       r;
    cl = first;
    for (int n = 1; n <= MAX_CHAIN_DEF; n++) begin
      lo_idx = cl[0] ? 3 * (cl >> 1) + 1 : 3 * (cl >> 1);
      if (!fat_loaded[lo_idx] || !fat_loaded[lo_idx + 1]) return 1'b0;
      if (cl[0]) nxt = {fat_image[lo_idx + 1], fat_image[lo_idx][7:4]};
      else nxt = {fat_image[lo_idx + 1][3:0], fat_image[lo_idx]};
      r.cluster = cl;
      r.sector  = SECTOR_W'(data_offset) + SECTOR_W'(cl);
      r.last    = (nxt == END_OF_CHAIN) || (n == MAX_CHAIN_DEF);
      r.trunc   = (nxt != END_OF_CHAIN) && (n == MAX_CHAIN_DEF);
      if (record) expected_sectors.push_back(r);
      if (r.last) break;
      cl = nxt;
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic send_item(input logic op, input logic [BYTE_ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] val, input logic [CLUSTER_W-1:0] cl);
    repeat (pending_gap) @(posedge clk_i);
    start_i         <= 1'b1;
    operation_i     <= op;
    byte_address_i  <= addr;
    byte_value_i    <= val;
    start_cluster_i <= cl;
    do @(posedge clk_i); while (busy_o);
    if (op == OP_WALK) begin
      void'(trace_chain(cl, 1'b1));
    end else begin
      fat_image[addr]  = val;
      fat_loaded[addr] = 1'b1;
    end
    items_sent++;
    pending_gap = pick_gap();
    if (pending_gap != 0) start_i <= 1'b0;
  endtask

  task automatic load_byte(input logic [BYTE_ADDR_W-1:0] addr, input logic [BYTE_W-1:0] val);
    send_item(OP_LOAD, addr, val, CLUSTER_W'($urandom));
  endtask

  // walks are only issued when every entry on the chain has been loaded
  task automatic walk(input logic [CLUSTER_W-1:0] cl);
    if (trace_chain(cl, 1'b0))
      send_item(OP_WALK, BYTE_ADDR_W'($urandom), BYTE_W'($urandom), cl);
  endtask

  // writes a 12-bit entry, keeping the neighbor's nibble in the shared byte
  task automatic set_entry(input logic [CLUSTER_W-1:0] cl, input logic [CLUSTER_W-1:0] value);
    int         lo_idx;
    logic [3:0] keep;
    lo_idx = cl[0] ? 3 * (cl >> 1) + 1 : 3 * (cl >> 1);
    if (cl[0]) begin
      keep = fat_loaded[lo_idx] ? fat_image[lo_idx][3:0] : 4'($urandom);
      load_byte(BYTE_ADDR_W'(lo_idx), {value[3:0], keep});
      load_byte(BYTE_ADDR_W'(lo_idx + 1), value[11:4]);
    end else begin
      keep = fat_loaded[lo_idx + 1] ? fat_image[lo_idx + 1][7:4] : 4'($urandom);
      load_byte(BYTE_ADDR_W'(lo_idx), value[7:0]);
      load_byte(BYTE_ADDR_W'(lo_idx + 1), {keep, value[11:8]});
    end
  endtask

  task automatic wait_idle();
    if (pending_gap == 0) start_i <= 1'b0;
    pending_gap = 0;
    do @(posedge clk_i); while (expected_sectors.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_offset(input logic [OFFSET_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    data_offset = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_table_edges();
    load_byte('0, 8'h00);
    load_byte('1, 8'hFF);
    load_byte(13'h1555, 8'hAA);
    load_byte(13'h0AAA, 8'h55);
  endtask

  task automatic test_single_clusters();
    set_entry(12'h000, END_OF_CHAIN);
    walk(12'h000);
    set_entry(END_OF_CHAIN, END_OF_CHAIN);
    walk(END_OF_CHAIN);
  endtask

  // free and reserved codes are followed like any cluster number
  task automatic test_reserved_codes();
    set_entry(12'h002, 12'h000);
    walk(12'h002);
    set_entry(12'h003, 12'hFF7);
    set_entry(12'hFF7, END_OF_CHAIN);
    walk(12'h003);
    set_entry(12'h005, END_OF_CHAIN);
    set_entry(END_OF_CHAIN, 12'h005);
    walk(END_OF_CHAIN);
  endtask

  task automatic test_truncation();
    set_entry(12'd10, 12'd10);
    walk(12'd10);
    set_entry(12'd20, 12'd21);
    set_entry(12'd21, 12'd20);
    walk(12'd21);
  endtask

  // exactly max length ending normally, and one short of it
  // clusters 100 on are packed pair by pair, three bytes per pair
  task automatic test_full_length_chain();
    logic [CLUSTER_W-1:0] e_even;
    logic [CLUSTER_W-1:0] e_odd;
    no_gaps = 1'b1;
    for (int p = 50; p < 50 + MAX_CHAIN_DEF / 2; p++) begin
      e_even = CLUSTER_W'(2 * p + 1);
      e_odd  = (2 * p + 1 == 99 + MAX_CHAIN_DEF) ? END_OF_CHAIN : CLUSTER_W'(2 * p + 2);
      load_byte(BYTE_ADDR_W'(3 * p), e_even[7:0]);
      load_byte(BYTE_ADDR_W'(3 * p + 1), {e_odd[3:0], e_even[11:8]});
      load_byte(BYTE_ADDR_W'(3 * p + 2), e_odd[11:4]);
    end
    no_gaps = 1'b0;
    walk(12'd100);
    walk(12'd101);
  endtask

  task automatic test_offset_settings();
    set_offset('0);
    walk(12'h000);
    walk(12'h002);
    set_offset('1);
    walk(END_OF_CHAIN);
    walk(12'hFF7);
    set_offset(OFFSET_W'($urandom));
    walk(12'd10);
    walk(12'd100);
  endtask

  task automatic test_random_traffic(input int n_items, input logic [OFFSET_W-1:0] offset);
    int                   stop_at;
    int                   len;
    int                   pick;
    logic [CLUSTER_W-1:0] chain[$];
    logic [CLUSTER_W-1:0] link;
    set_offset(offset);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick    = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (pick < 75) begin
        // a file: random clusters linked in order, usually ending at end-of-chain
        chain.delete();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        repeat (len) chain.push_back(CLUSTER_W'($urandom));
        for (int i = 0; i < len; i++) begin
          if (i < len - 1) link = chain[i + 1];
          else if ($urandom_range(0, 9) != 0) link = END_OF_CHAIN;
          else link = chain[$urandom_range(0, len - 1)];
          set_entry(chain[i], link);
        end
        walk(chain[0]);
        if ($urandom_range(0, 2) == 0) walk(chain[$urandom_range(0, len - 1)]);
        foreach (chain[i]) known_clusters.push_back(chain[i]);
      end else if (pick < 90) begin
        load_byte(BYTE_ADDR_W'($urandom), BYTE_W'($urandom));
      end else if (known_clusters.size() != 0 && $urandom_range(0, 1)) begin
        walk(known_clusters[$urandom_range(0, known_clusters.size() - 1)]);
      end else begin
        walk(CLUSTER_W'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_sectors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: sector %0d cluster %0d last %0b trunc %0b",
                   sector_address_o, cluster_number_o, last_of_chain_o, chain_truncated_o);
      end else begin
        want = expected_sectors.pop_front();
        if (sector_address_o !== want.sector || cluster_number_o !== want.cluster ||
            last_of_chain_o !== want.last || chain_truncated_o !== want.trunc) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected sector %0d cluster %0d last %0b trunc %0b, got %0d %0d %0b %0b",
                     want.sector, want.cluster, want.last, want.trunc, sector_address_o,
                     cluster_number_o, last_of_chain_o, chain_truncated_o);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_edges();
    test_single_clusters();
    test_reserved_codes();
    test_truncation();
    test_full_length_chain();
    test_offset_settings();
    test_random_traffic(8, OFFSET_W'($urandom));
    test_random_traffic(8, '1);
    test_random_traffic(8, OFFSET_RESET);
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (expected_sectors.size() != 0) begin
      $display("%0d expected results never arrived", expected_sectors.size());
      mismatch_count += expected_sectors.size();
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
